>>> hw/rtl/multichannel_biquad_filter_top_defines.svh
// Assertion macros shared by the multichannel biquad filter checker.
// Depends on nothing; files that assert take it by include.
`ifndef MULTICHANNEL_BIQUAD_FILTER_TOP_DEFINES_SVH
`define MULTICHANNEL_BIQUAD_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MBQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MBQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/mbq_pkg.sv
// Package for the multichannel biquad filter: widths, register codes and types.
// Used by every module and interface of the block; depends on nothing.
package mbq_pkg;

  // Sample and coefficient formats.
  localparam int SAMPLE_BITS    = 24;
  localparam int CHAN_BITS      = 4;
  localparam int COEF_BITS      = 32;
  localparam int COEF_FRAC_BITS = 28;

  // Configuration port.
  localparam int NUM_REGS   = 5;
  localparam int ADDR_BITS  = 5;
  localparam int DATA_BITS  = 32;
  localparam int REG_IDX_BITS = 3;

  localparam logic [REG_IDX_BITS-1:0] REG_B0 = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_B1 = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_B2 = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_A1 = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_A2 = 3'd4;

  // Reset value of b0 is unity gain.
  localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(64'd1 << COEF_FRAC_BITS);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;

  // Full coefficient set seen by the datapath.
  typedef struct packed {
    coef_t b0;
    coef_t b1;
    coef_t b2;
    coef_t a1;
    coef_t a2;
  } coef_set_t;

  // One channel's history.
  typedef struct packed {
    sample_t x1;
    sample_t x2;
    sample_t y1;
    sample_t y2;
  } hist_t;

endpackage

>>> hw/rtl/mbq_in_if.sv
// Input stream interface of the biquad filter: valid/ready plus one sample request.
// Depends on mbq_pkg.
interface mbq_in_if
  import mbq_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic [CHAN_BITS-1:0]   channel;
  logic                 block_end;

  modport source (output valid, in_sample, channel, block_end, input ready);
  modport sink   (input valid, in_sample, channel, block_end, output ready);
endinterface

>>> hw/rtl/mbq_out_if.sv
// Output stream interface of the biquad filter: valid/ready plus one result request.
// Depends on mbq_pkg.
interface mbq_out_if
  import mbq_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [SAMPLE_BITS-1:0] out_sample;
  logic [CHAN_BITS-1:0]   out_channel;
  logic                 out_block_end;

  modport source (output valid, out_sample, out_channel, out_block_end, input ready);
  modport sink   (input valid, out_sample, out_channel, out_block_end, output ready);
endinterface

>>> hw/rtl/multichannel_biquad_filter_top.sv
// Multichannel biquad filter, Direct Form I, with an APB-style coefficient port.
// Depends on mbq_pkg, mbq_in_if, mbq_out_if, mbq_regs, mbq_hist and mbq_dp.
//
// Usage: each request on in_i carries one Q1.23 sample, a channel number and a
// block end flag. A channel below CHANNELS is filtered with the shared
// coefficient set and that channel's own history; any other channel passes the
// sample through and leaves all history untouched. Every request gives exactly
// one result request on out_o, in order, with channel and block end echoed.
// A request is held in the input register, and its result is offered from the
// result register. One request is accepted per cycle unless out_o stalls: the
// filter evaluates a whole sample combinationally between the two registers,
// and the history write of one sample is visible to the next one on the same
// channel. The input register keeps taking one request while a result waits on
// a stalled receiver; with both registers full, in_i.ready drops until out_o is
// drained. Reset clears all history to zero, sets b0 to unity and the other
// coefficients to zero. Coefficients are to be written through the APB port only
// while the stream idles; the block itself does not enforce this.
module multichannel_biquad_filter_top
  import mbq_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mbq_in_if.sink               in_i,
  mbq_out_if.source            out_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CHAN_BITS:0] ChanLimit = CHANNELS[CHAN_BITS:0];

  coef_set_t             coef;
  hist_t                 hist;
  sample_t               filt_y;
  sample_t               res_y;

  logic                  in_valid_q;
  sample_t               in_sample_q;
  logic [CHAN_BITS-1:0]  channel_q;
  logic                  block_end_q;

  logic                  out_valid_q;
  sample_t               out_sample_q;
  logic [CHAN_BITS-1:0]  out_channel_q;
  logic                  out_block_end_q;

  logic                  advance;
  logic                  in_take;
  logic                  chan_hit;

  // Coefficient registers.
  mbq_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef_o  (coef)
  );

  // Handshake: the input stage moves on when the result register is free.
  assign advance  = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_take  = in_i.valid && in_i.ready;
  assign chan_hit = {1'b0, channel_q} < ChanLimit;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_sample_q <= in_i.in_sample;
      channel_q   <= in_i.channel;
      block_end_q <= in_i.block_end;
    end
  end

  // Channel history.
  mbq_hist #(
    .CHANNELS (CHANNELS),
    .IDX_W    (IDX_W)
  ) u_hist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .idx_i  (channel_q[IDX_W-1:0]),
    .we_i   (advance && chan_hit),
    .x_i    (in_sample_q),
    .y_i    (filt_y),
    .hist_o (hist)
  );

  // Filter arithmetic.
  mbq_dp u_dp (
    .x_i    (in_sample_q),
    .hist_i (hist),
    .coef_i (coef),
    .y_o    (filt_y)
  );

  assign res_y = chan_hit ? filt_y : in_sample_q;

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_sample_q    <= res_y;
      out_channel_q   <= channel_q;
      out_block_end_q <= block_end_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_sample    = out_sample_q;
  assign out_o.out_channel   = out_channel_q;
  assign out_o.out_block_end = out_block_end_q;

endmodule

>>> hw/rtl/mbq_regs.sv
// Coefficient register file behind an APB-style write/read port.
// Depends on mbq_pkg.
module mbq_regs
  import mbq_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  output coef_set_t            coef_o
);

  logic [REG_IDX_BITS-1:0] reg_idx;
  logic                    wr_en;
  coef_set_t               coef_q;

  assign reg_idx = paddr[ADDR_BITS-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;

  // Register writes; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.b0 <= COEF_ONE;
      coef_q.b1 <= '0;
      coef_q.b2 <= '0;
      coef_q.a1 <= '0;
      coef_q.a2 <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_B0:  coef_q.b0 <= pwdata;
        REG_B1:  coef_q.b1 <= pwdata;
        REG_B2:  coef_q.b2 <= pwdata;
        REG_A1:  coef_q.a1 <= pwdata;
        REG_A2:  coef_q.a2 <= pwdata;
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    case (reg_idx)
      REG_B0:  prdata = coef_q.b0;
      REG_B1:  prdata = coef_q.b1;
      REG_B2:  prdata = coef_q.b2;
      REG_A1:  prdata = coef_q.a1;
      REG_A2:  prdata = coef_q.a2;
      default: prdata = '0;
    endcase
  end

  assign coef_o = coef_q;

endmodule

>>> hw/rtl/mbq_hist.sv
// Per-channel filter history: two past inputs and two past outputs per channel.
// Depends on mbq_pkg.
module mbq_hist
  import mbq_pkg::*;
#(
  parameter int CHANNELS = 8,
  parameter int IDX_W    = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] idx_i,
  input  logic             we_i,
  input  sample_t          x_i,
  input  sample_t          y_i,
  output hist_t            hist_o
);

  hist_t hist_q [CHANNELS];

  // Shift the addressed channel's history by one sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        hist_q[c] <= '0;
      end
    end else if (we_i) begin
      hist_q[idx_i].x2 <= hist_q[idx_i].x1;
      hist_q[idx_i].x1 <= x_i;
      hist_q[idx_i].y2 <= hist_q[idx_i].y1;
      hist_q[idx_i].y1 <= y_i;
    end
  end

  assign hist_o = hist_q[idx_i];

endmodule

>>> hw/rtl/mbq_dp.sv
// Biquad arithmetic: five products, exact sum, round to nearest and saturate.
// Depends on mbq_pkg.
module mbq_dp
  import mbq_pkg::*;
(
  input  sample_t   x_i,
  input  hist_t     hist_i,
  input  coef_set_t coef_i,
  output sample_t   y_o
);

  localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
  localparam int ACC_W  = PROD_W + 3;
  localparam int Q_W    = ACC_W - COEF_FRAC_BITS;

  localparam logic signed [ACC_W-1:0] Half = ACC_W'(64'd1 << (COEF_FRAC_BITS - 1));
  localparam logic signed [Q_W-1:0] MaxQ = Q_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [Q_W-1:0] MinQ = ~MaxQ;

  logic signed [PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [Q_W-1:0]    q;

  // Five independent products of coefficient and sample.
  assign p_b0 = coef_i.b0 * x_i;
  assign p_b1 = coef_i.b1 * hist_i.x1;
  assign p_b2 = coef_i.b2 * hist_i.x2;
  assign p_a1 = coef_i.a1 * hist_i.y1;
  assign p_a2 = coef_i.a2 * hist_i.y2;

  // Exact sum, with the feedback terms subtracted.
  assign acc = {{3{p_b0[PROD_W-1]}}, p_b0} + {{3{p_b1[PROD_W-1]}}, p_b1}
             + {{3{p_b2[PROD_W-1]}}, p_b2} - {{3{p_a1[PROD_W-1]}}, p_a1}
             - {{3{p_a2[PROD_W-1]}}, p_a2};

  // Add one half, then floor by the fraction bits.
  assign acc_rnd = acc + Half;
  assign q       = acc_rnd[ACC_W-1:COEF_FRAC_BITS];

  // Saturate to the sample range.
  always_comb begin
    if (q > MaxQ) begin
      y_o = MaxQ[SAMPLE_BITS-1:0];
    end else if (q < MinQ) begin
      y_o = MinQ[SAMPLE_BITS-1:0];
    end else begin
      y_o = q[SAMPLE_BITS-1:0];
    end
  end

endmodule

>>> hw/rtl/mbq_assert.sv
// Port-level assertions for the multichannel biquad filter, bound to the top level.
// Depends on mbq_pkg and multichannel_biquad_filter_top_defines.svh.
`include "multichannel_biquad_filter_top_defines.svh"

module mbq_assert
  import mbq_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [SAMPLE_BITS-1:0] out_sample_i,
  input logic [CHAN_BITS-1:0]   out_channel_i,
  input logic                   out_block_end_i,
  input logic                   psel_i,
  input logic                   penable_i,
  input logic                   pwrite_i,
  input logic [ADDR_BITS-1:0]   paddr_i,
  input logic [DATA_BITS-1:0]   pwdata_i,
  input logic [DATA_BITS-1:0]   prdata_i
);

  logic out_stall;
  logic in_wait;
  logic cfg_wr_known;

  assign out_stall    = out_valid_i && !out_ready_i;
  assign in_wait      = in_valid_i && !in_ready_i;
  assign cfg_wr_known = psel_i && penable_i && pwrite_i
                        && (paddr_i[ADDR_BITS-1:2] < REG_IDX_BITS'(NUM_REGS));

  // A stalled result stays offered.
  `MBQ_ASSERT_NXT(a_out_valid_hold, clk_i, rst_ni, out_stall, out_valid_i, "result dropped while stalled")

  // A stalled result keeps its payload.
  `MBQ_ASSERT_NXT(a_out_data_hold, clk_i, rst_ni, out_stall, $stable(out_sample_i) && $stable(out_channel_i) && $stable(out_block_end_i), "result changed while stalled")

  // A waiting request stays offered until it is taken.
  `MBQ_ASSERT_NXT(a_in_valid_hold, clk_i, rst_ni, in_wait, in_valid_i, "request withdrawn while waiting")

  // Input back-pressure only comes from a stalled receiver.
  `MBQ_ASSERT_IMP(a_ready_cause, clk_i, rst_ni, !in_ready_i, out_valid_i && !out_ready_i, "input blocked without a stalled result")

  // A written coefficient reads back at the same address.
  `MBQ_ASSERT_NXT(a_cfg_readback, clk_i, rst_ni, cfg_wr_known, (paddr_i != $past(paddr_i)) || (prdata_i == $past(pwdata_i)), "coefficient read-back mismatch")

endmodule

bind multichannel_biquad_filter_top mbq_assert u_mbq_assert (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_sample_i    (out_o.out_sample),
  .out_channel_i   (out_o.out_channel),
  .out_block_end_i (out_o.out_block_end),
  .psel_i          (psel),
  .penable_i       (penable),
  .pwrite_i        (pwrite),
  .paddr_i         (paddr),
  .pwdata_i        (pwdata),
  .prdata_i        (prdata)
);

>>> dv/testbench.sv
// Self-checking testbench for multichannel_biquad_filter_top: directed and random
// sample requests, APB coefficient programming, and a bit-exact filter predictor.
// Depends on mbq_pkg, mbq_in_if, mbq_out_if and the filter RTL.
`timescale 1ns / 100ps

module testbench;
  import mbq_pkg::*;

  localparam int NUM_CH = 8;
  localparam int RAND_ITEMS = 576;
  localparam int SEGMENTS = 6;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_PRINTED = 100;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam coef_t COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam coef_t COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};
  localparam coef_t COEF_HALF = COEF_ONE >>> 1;

  typedef enum {COEF_MILD, COEF_WILD, COEF_EDGES} coef_mode_e;

  // One sample request or one filtered result; both carry the same fields.
  typedef struct packed {
    sample_t                sample;
    logic [CHAN_BITS-1:0]   chan;
    logic                   blk_end;
  } stream_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  mbq_in_if  in_bus ();
  mbq_out_if out_bus ();

  multichannel_biquad_filter_top #(
    .CHANNELS(NUM_CH)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Filter state mirrored by the predictor.
  coef_t   coef_shadow [NUM_REGS];
  sample_t hist_x1 [1 << CHAN_BITS];
  sample_t hist_x2 [1 << CHAN_BITS];
  sample_t hist_y1 [1 << CHAN_BITS];
  sample_t hist_y2 [1 << CHAN_BITS];

  stream_word_t pending_reqs[$];
  stream_word_t expected_results[$];

  int unsigned src_gap_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  always #5 clk_i = ~clk_i;

  // Compute the filtered result of one request and advance that channel's history.
  function automatic stream_word_t filter_sample(stream_word_t req);
    stream_word_t res;
    longint acc;
    longint q;
    int ch;
    res = req;
    ch = int'(req.chan);
    if (ch < NUM_CH) begin
      acc = longint'(coef_shadow[REG_B0]) * longint'(req.sample)
          + longint'(coef_shadow[REG_B1]) * longint'(hist_x1[ch])
          + longint'(coef_shadow[REG_B2]) * longint'(hist_x2[ch])
          - longint'(coef_shadow[REG_A1]) * longint'(hist_y1[ch])
          - longint'(coef_shadow[REG_A2]) * longint'(hist_y2[ch]);
      // Round to nearest with ties toward plus infinity, then saturate.
      q = (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
      if (q > longint'(SAMPLE_MAX)) q = longint'(SAMPLE_MAX);
      if (q < longint'(SAMPLE_MIN)) q = longint'(SAMPLE_MIN);
      res.sample = sample_t'(q);
      hist_x2[ch] = hist_x1[ch];
      hist_x1[ch] = req.sample;
      hist_y2[ch] = hist_y1[ch];
      hist_y1[ch] = res.sample;
    end
    return res;
  endfunction

  task automatic report_mismatch(string field, longint exp_val, longint got_val);
    if (mismatch_count < MAX_PRINTED)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, field, exp_val, got_val);
    mismatch_count++;
  endtask

  // Driver: offers pending requests, holding each until it is accepted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) begin
        expected_results.push_back(filter_sample({in_bus.in_sample, in_bus.channel,
                                                  in_bus.block_end}));
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
          in_bus.valid     <= 1'b1;
          in_bus.in_sample <= pending_reqs[0].sample;
          in_bus.channel   <= pending_reqs[0].chan;
          in_bus.block_end <= pending_reqs[0].blk_end;
          void'(pending_reqs.pop_front());
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, sample", 0, $signed(out_bus.out_sample));
        end else begin
          if (out_bus.out_sample !== expected_results[0].sample)
            report_mismatch("out_sample", expected_results[0].sample,
                            $signed(out_bus.out_sample));
          if (out_bus.out_channel !== expected_results[0].chan)
            report_mismatch("out_channel", expected_results[0].chan, out_bus.out_channel);
          if (out_bus.out_block_end !== expected_results[0].blk_end)
            report_mismatch("out_block_end", expected_results[0].blk_end,
                            out_bus.out_block_end);
          void'(expected_results.pop_front());
        end
      end
      out_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("multichannel_biquad_filter_top regression: fail");
      $finish;
    end
  end

  task automatic push_req(sample_t sample, int ch, bit blk_end);
    pending_reqs.push_back({sample, CHAN_BITS'(ch), blk_end});
  endtask

  // Wait until every request has been accepted and every result checked.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || in_bus.valid || expected_results.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle.
  task automatic reg_write(logic [REG_IDX_BITS-1:0] idx, logic [DATA_BITS-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BITS'(idx) << 2;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (int'(idx) < NUM_REGS) coef_shadow[idx] = coef_t'(value);
  endtask

  task automatic program_coefs(coef_t b0, coef_t b1, coef_t b2, coef_t a1, coef_t a2);
    reg_write(REG_B0, b0);
    reg_write(REG_B1, b1);
    reg_write(REG_B2, b2);
    reg_write(REG_A1, a1);
    reg_write(REG_A2, a2);
  endtask

  function automatic coef_t rand_coef(coef_mode_e mode, int unsigned span);
    case (mode)
      COEF_MILD: return coef_t'(int'($urandom_range(0, 2 * span)) - int'(span));
      COEF_WILD: return coef_t'($urandom());
      default: begin
        case ($urandom_range(3))
          0: return COEF_MAX;
          1: return COEF_MIN;
          2: return '0;
          default: return COEF_ONE;
        endcase
      end
    endcase
  endfunction

  // Mostly moderate audio levels, with full-scale noise and the range extremes.
  function automatic sample_t rand_sample();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 60) return sample_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
    if (pick < 85) return sample_t'($urandom());
    case ($urandom_range(4))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return '0;
      3: return sample_t'(1);
      default: return sample_t'(-1);
    endcase
  endfunction

  initial begin
    coef_mode_e mode;
    int ch;

    // Known values on every input before reset is released.
    in_bus.valid     = 1'b0;
    in_bus.in_sample = '0;
    in_bus.channel   = '0;
    in_bus.block_end = 1'b0;
    out_bus.ready    = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;

    coef_shadow[REG_B0] = COEF_ONE;
    for (int r = 1; r < NUM_REGS; r++) coef_shadow[r] = '0;
    for (int c = 0; c < (1 << CHAN_BITS); c++) begin
      hist_x1[c] = '0;
      hist_x2[c] = '0;
      hist_y1[c] = '0;
      hist_y2[c] = '0;
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Unity gain after reset: filtered channels and pass-through channels alike.
    src_gap_pct = 7;
    sink_stall_pct = 73;
    push_req(SAMPLE_MAX, 0, 1'b0);
    push_req(SAMPLE_MIN, 0, 1'b0);
    push_req('0, 0, 1'b0);
    push_req(sample_t'(1), 0, 1'b0);
    push_req(sample_t'(-1), 0, 1'b1);
    push_req(SAMPLE_MAX, NUM_CH - 1, 1'b1);
    push_req(SAMPLE_MIN, NUM_CH, 1'b0);
    push_req(SAMPLE_MAX, 15, 1'b1);
    wait_idle();

    // Writes beyond the last register must leave the coefficients alone.
    for (int r = NUM_REGS; r < (1 << REG_IDX_BITS); r++) begin
      reg_write(REG_IDX_BITS'(r), $urandom());
    end

    // Overflow in both directions: the saturated value is emitted and kept as history.
    program_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN);
    push_req(SAMPLE_MAX, 1, 1'b0);
    push_req(SAMPLE_MAX, 1, 1'b0);
    push_req(SAMPLE_MAX, 1, 1'b0);
    push_req(SAMPLE_MIN, 1, 1'b1);
    push_req(SAMPLE_MAX, 9, 1'b0);
    wait_idle();
    program_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX);
    push_req(SAMPLE_MAX, 2, 1'b0);
    push_req(SAMPLE_MIN, 2, 1'b0);
    push_req(SAMPLE_MIN, 1, 1'b1);
    wait_idle();

    // Half gain exercises rounding ties toward plus infinity.
    program_coefs(COEF_HALF, '0, '0, '0, '0);
    push_req(sample_t'(1), 3, 1'b0);
    push_req(sample_t'(-1), 3, 1'b0);
    push_req(sample_t'(3), 3, 1'b0);
    push_req(sample_t'(-3), 3, 1'b1);
    wait_idle();

    // Random segments; each pair of segments uses one idling profile.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 2)
        0: begin
          src_gap_pct = 7;
          sink_stall_pct = 73;
        end
        1: begin
          src_gap_pct = 73;
          sink_stall_pct = 7;
        end
        default: begin
          src_gap_pct = 0;
          sink_stall_pct = 0;
        end
      endcase
      mode = (seg % 3 == 0) ? COEF_MILD : (seg % 3 == 1) ? COEF_WILD : COEF_EDGES;
      program_coefs(rand_coef(mode, 1 << 27), rand_coef(mode, 1 << 27),
                    rand_coef(mode, 1 << 27), rand_coef(mode, 1 << 29),
                    rand_coef(mode, 15 << 24));
      for (int n = 0; n < RAND_ITEMS / SEGMENTS; n++) begin
        if ($urandom_range(99) < 80) ch = $urandom_range(NUM_CH - 1);
        else ch = $urandom_range(15, NUM_CH);
        push_req(rand_sample(), ch, $urandom_range(7) == 0);
      end
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("multichannel_biquad_filter_top regression: pass");
    end else begin
      $display("multichannel_biquad_filter_top regression: fail");
    end
    $finish;
  end

endmodule
